### sv/pwmns_pkg.sv
package pwmns_pkg;

  localparam int SampleWidth = 16;
  localparam int PeriodWidth = 16;
  localparam int DutyWidth   = PeriodWidth + 1;
  localparam int IndexWidth  = 8;

  // register indexes on the configuration port
  localparam logic [IndexWidth-1:0] REG_PWM_PERIOD     = 8'd0;
  localparam logic [IndexWidth-1:0] REG_SHAPING_ENABLE = 8'd1;

  localparam logic [PeriodWidth-1:0] PWM_PERIOD_RESET     = 16'd255;
  localparam logic                   SHAPING_ENABLE_RESET = 1'b1;

  // flips a two's complement sample into offset binary
  localparam logic [SampleWidth-1:0] SIGN_FLIP = 16'h8000;
  // half of one step in Q16
  localparam logic [33:0] ROUND_HALF = 34'd32768;

  typedef struct packed {
    logic [PeriodWidth-1:0] pwm_period;
    logic                   shaping_enable;
  } cfg_t;

endpackage

### sv/pwmns_duty.sv
module pwmns_duty (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic signed [pwmns_pkg::SampleWidth-1:0] sample,
  input  pwmns_pkg::cfg_t                         cfg,
  output logic [pwmns_pkg::DutyWidth-1:0]         duty
);
  import pwmns_pkg::*;

  // feedback error in Q16 steps, always within one half step
  logic signed [15:0]        quant_error;
  logic signed [15:0]        quant_error_next;
  logic [15:0]               offset;
  logic [DutyWidth-1:0]      steps;
  logic [31:0]               product;
  logic [31:0]               target;
  logic signed [33:0]        shaped;
  logic [33:0]               rsum;
  logic [17:0]               rounded;
  logic [15:0]               trunc;
  logic                      shaped_low;
  logic [DutyWidth-1:0]      duty_next;

  always_comb begin
    offset     = sample ^ SIGN_FLIP;
    steps      = {1'b0, cfg.pwm_period} + 17'd1;
    // at most 65535 * 65536, fits in 32 bits
    product    = {16'b0, offset} * {15'b0, steps};
    target     = product;
    shaped     = $signed({2'b00, target}) + 34'(quant_error);
    rsum       = unsigned'(shaped) + ROUND_HALF;
    rounded    = rsum[33:16];
    trunc      = target[31:16];
    shaped_low = shaped[33] || (shaped == 34'sd0);

    if (cfg.shaping_enable) begin
      if (shaped_low) begin
        duty_next        = '0;
        quant_error_next = '0;
      end else if (rounded > {1'b0, steps}) begin
        duty_next        = steps;
        quant_error_next = '0;
      end else begin
        duty_next        = rounded[DutyWidth-1:0];
        // remainder after rounding, recentred around zero
        quant_error_next = signed'(rsum[15:0] ^ SIGN_FLIP);
      end
    end else begin
      duty_next        = (trunc > cfg.pwm_period) ? {1'b0, cfg.pwm_period} : {1'b0, trunc};
      quant_error_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_error <= '0;
    end else if (en) begin
      quant_error <= quant_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty <= duty_next;
    end
  end

  a_err_clear_unshaped: assert property (@(posedge clk) disable iff (rst)
    en && !cfg.shaping_enable |=> quant_error == 16'sd0)
    else $error("error not cleared on an unshaped beat");

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    en |=> duty <= $past(steps))
    else $error("duty above step count");

  a_duty_unshaped_cap: assert property (@(posedge clk) disable iff (rst)
    en && !cfg.shaping_enable |=> duty <= {1'b0, $past(cfg.pwm_period)})
    else $error("unshaped duty above period");

endmodule

### sv/pwmns_level.sv
module pwmns_level (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic signed [pwmns_pkg::SampleWidth-1:0] sample,
  output logic                                    clipped,
  output logic [pwmns_pkg::SampleWidth-1:0]       peak_store,
  output logic [pwmns_pkg::SampleWidth-1:0]       smooth_store
);
  import pwmns_pkg::*;

  logic [SampleWidth-1:0] mag;
  logic [20:0]            smooth_sum;
  logic [SampleWidth-1:0] smooth_store_next;
  logic [SampleWidth-1:0] peak_store_next;
  logic                   clipped_next;

  always_comb begin
    // magnitude of the most negative sample wraps to 0x8000, which is exact
    mag               = sample[SampleWidth-1] ? (~sample + 16'd1) : sample;
    clipped_next      = (sample == 16'sh7fff) || (sample == 16'sh8000);
    peak_store_next   = (mag > peak_store) ? mag : peak_store;
    // old*31 as old*32 - old
    smooth_sum        = {smooth_store, 5'b0} - {5'b0, smooth_store} + {5'b0, mag};
    smooth_store_next = smooth_sum[20:5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_store   <= '0;
      smooth_store <= '0;
    end else if (en) begin
      peak_store   <= peak_store_next;
      smooth_store <= smooth_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clipped <= clipped_next;
    end
  end

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    en |=> peak_store >= $past(peak_store))
    else $error("peak level decreased");

  a_peak_covers_sample: assert property (@(posedge clk) disable iff (rst)
    en |=> peak_store >= $past(mag))
    else $error("peak below current magnitude");

  a_smooth_bounded: assert property (@(posedge clk) disable iff (rst)
    smooth_store <= 16'd32768)
    else $error("smoothed level out of range");

endmodule

### sv/pwm_audio_noise_shaped_duty_unit.sv
// noise-shaped pwm duty unit: each input beat carries one signed 16-bit audio
// sample (one per pwm period) and yields one output beat with the pwm compare
// value, a full-scale clip flag, the peak magnitude since reset and a 31/32
// smoothed level. the sample is offset to unsigned and scaled by the step count
// (pwm_period + 1); with shaping on, the previous quantization error is added,
// the sum is rounded to whole steps and the remainder is fed back, and the error
// is dropped whenever duty is clamped to 0 or to pwm_period + 1 (constant high).
// with shaping off, duty is truncated and capped at pwm_period and the error is
// cleared. the unit takes one beat per clock cycle while out_stall is low. an
// input register and a result register hold each beat, with the 16x17 multiply,
// the error add and the rounding compare in between. the error feedback closes
// within the result stage, so back-to-back samples are shaped in order. the
// result register holds while it has a beat and out_stall is high; the input
// register keeps taking a beat while it is empty. configuration is written at
// any cycle with cfg_we; index 0 is pwm_period, index 1 is shaping_enable, other
// indexes are ignored; write only when no beat is in flight.
module pwm_audio_noise_shaped_duty_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration port
  input  logic                                    cfg_we,
  input  logic [pwmns_pkg::IndexWidth-1:0]        cfg_index,
  input  logic [pwmns_pkg::PeriodWidth-1:0]       cfg_data,
  // sample channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pwmns_pkg::SampleWidth-1:0] sample_in,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [pwmns_pkg::DutyWidth-1:0]         duty,
  output logic                                    clipped,
  output logic [pwmns_pkg::SampleWidth-1:0]       peak_level,
  output logic [pwmns_pkg::SampleWidth-1:0]       smooth_level
);
  import pwmns_pkg::*;

  cfg_t                          cfg;
  // input register
  logic                          s1_valid;
  logic signed [SampleWidth-1:0] s1_sample;
  // pipe control
  logic                          adv;
  logic                          en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period     <= PWM_PERIOD_RESET;
      cfg.shaping_enable <= SHAPING_ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD:     cfg.pwm_period     <= cfg_data;
        REG_SHAPING_ENABLE: cfg.shaping_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register may load when empty or when its beat is taken now
  assign adv      = !out_valid || !out_stall;
  // a held sample moves into the result register, updating all state
  assign en       = s1_valid && adv;
  // input register frees up when empty or when it moves on this cycle
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample_in;
    end
  end

  // duty value with error feedback
  pwmns_duty u_duty (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .sample (s1_sample),
    .cfg    (cfg),
    .duty   (duty)
  );

  // clip flag, peak and smoothed level
  pwmns_level u_level (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .sample       (s1_sample),
    .clipped      (clipped),
    .peak_store   (peak_level),
    .smooth_store (smooth_level)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipe");

  a_result_follows_input: assert property (@(posedge clk) disable iff (rst)
    en |=> out_valid)
    else $error("advanced beat did not reach the result register");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !s1_valid |=> !out_valid)
    else $error("result appeared with empty pipe");

endmodule

### tb/sv/pwm_duty_checker.sv
`timescale 1ns / 1ps

module pwm_duty_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [pwmns_pkg::IndexWidth-1:0]        cfg_index,
  input  logic [pwmns_pkg::PeriodWidth-1:0]       cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic signed [pwmns_pkg::SampleWidth-1:0] sample_in,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic [pwmns_pkg::DutyWidth-1:0]         duty,
  input  logic                                    clipped,
  input  logic [pwmns_pkg::SampleWidth-1:0]       peak_level,
  input  logic [pwmns_pkg::SampleWidth-1:0]       smooth_level,
  output int                                      fail_count,
  output int                                      pending
);
  import pwmns_pkg::*;

  typedef struct packed {
    logic [DutyWidth-1:0]   duty;
    logic                   clipped;
    logic [SampleWidth-1:0] peak;
    logic [SampleWidth-1:0] smooth;
  } duty_beat_t;

  logic [PeriodWidth-1:0] period_q;
  logic                   shaping_q;
  logic signed [16:0]     shape_err;
  logic [SampleWidth-1:0] peak_q;
  logic [SampleWidth-1:0] smooth_q;
  duty_beat_t             duty_q[$];

  // advances the shaper state by one sample and returns the beat it should produce
  function automatic duty_beat_t shape_sample(logic signed [SampleWidth-1:0] s);
    duty_beat_t             beat;
    logic [SampleWidth-1:0] offset;
    longint                 steps;
    longint                 shaped;
    longint                 rounded;
    longint                 d;
    int                     sv;
    int                     mag;
    offset = s ^ SIGN_FLIP;
    steps  = longint'(period_q) + 1;
    if (shaping_q) begin
      shaped = longint'(offset) * steps + longint'(shape_err);
      if (shaped <= 0) begin
        d         = 0;
        shape_err = '0;
      end else begin
        rounded = (shaped + 32768) / 65536;
        if (rounded > steps) begin
          d         = steps;
          shape_err = '0;
        end else begin
          d         = rounded;
          shape_err = 17'(shaped - d * 65536);
        end
      end
    end else begin
      d = (longint'(offset) * steps) >> 16;
      if (d > longint'(period_q)) d = longint'(period_q);
      shape_err = '0;
    end
    sv  = int'(s);
    mag = (sv < 0) ? -sv : sv;
    if (mag > int'(peak_q)) peak_q = 16'(mag);
    smooth_q     = 16'((int'(smooth_q) * 31 + mag) / 32);
    beat.duty    = DutyWidth'(d);
    beat.clipped = (sv == 32767 || sv == -32768);
    beat.peak    = peak_q;
    beat.smooth  = smooth_q;
    return beat;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    duty_beat_t want;
    if (rst) begin
      period_q  = PWM_PERIOD_RESET;
      shaping_q = SHAPING_ENABLE_RESET;
      shape_err = '0;
      peak_q    = '0;
      smooth_q  = '0;
      duty_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PWM_PERIOD:     period_q = cfg_data;
          REG_SHAPING_ENABLE: shaping_q = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (duty_q.size() == 0) begin
          $display("%0t unexpected beat: duty %0d clipped %0d peak %0d smooth %0d",
                   $time, duty, clipped, peak_level, smooth_level);
          fail_count++;
        end else begin
          want = duty_q.pop_front();
          check_field("duty", want.duty, duty);
          check_field("clipped", want.clipped, clipped);
          check_field("peak_level", want.peak, peak_level);
          check_field("smooth_level", want.smooth, smooth_level);
        end
      end
      if (in_valid && !in_stall) duty_q.push_back(shape_sample(sample_in));
    end
    pending <= duty_q.size();
  end

endmodule

### tb/sv/pwm_audio_noise_shaped_duty_unit_tb.sv
`timescale 1ns / 1ps

module pwm_audio_noise_shaped_duty_unit_tb;
  import pwmns_pkg::*;

  // indexes past the register map, writes to them must be dropped
  localparam logic [IndexWidth-1:0] UNMAPPED_INDEX_LOW  = 8'd2;
  localparam logic [IndexWidth-1:0] UNMAPPED_INDEX_HIGH = 8'hFF;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [IndexWidth-1:0]         cfg_index = '0;
  logic [PeriodWidth-1:0]        cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SampleWidth-1:0] sample_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [DutyWidth-1:0]          duty;
  logic                          clipped;
  logic [SampleWidth-1:0]        peak_level;
  logic [SampleWidth-1:0]        smooth_level;
  int                            fail_count;
  int                            pending;

  // percent of cycles the sample side idles and the result side stalls
  int gap_pct   = 0;
  int stall_pct = 0;

  always #6 clk = ~clk;

  pwm_audio_noise_shaped_duty_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .clipped      (clipped),
    .peak_level   (peak_level),
    .smooth_level (smooth_level)
  );

  pwm_duty_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .clipped      (clipped),
    .peak_level   (peak_level),
    .smooth_level (smooth_level),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // offers one sample beat, with random idle cycles ahead of it, and returns
  // at the edge where it is taken
  task automatic send_sample(logic signed [SampleWidth-1:0] s);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stops sending and waits until every predicted beat has come back,
  // then lets the two pipeline stages run dry
  task automatic settle_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; only called with the pipeline empty
  task automatic write_reg(logic [IndexWidth-1:0] idx, logic [PeriodWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                            phase;
    int                            k;
    int                            pick;
    int                            trend;
    logic signed [SampleWidth-1:0] s;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed beats ---
    // reset settings: period 255, shaping on; zero, both full-scale ends
    // (clip flag, magnitude of the most negative sample), the smallest steps
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd12345);
    settle_outputs();

    // period zero: a single step per period
    write_reg(REG_PWM_PERIOD, 16'd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    settle_outputs();

    // widest period, plain truncation: duty must stop at pwm_period
    write_reg(REG_PWM_PERIOD, 16'hFFFF);
    write_reg(REG_SHAPING_ENABLE, 16'd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    settle_outputs();

    // shaping back on, then toggle it off and on with no beat in between:
    // the carried error must survive; unmapped writes must change nothing
    write_reg(REG_PWM_PERIOD, 16'd1000);
    write_reg(REG_SHAPING_ENABLE, 16'd1);
    send_sample(16'sd111);
    send_sample(-16'sd222);
    settle_outputs();
    write_reg(REG_SHAPING_ENABLE, 16'd0);
    write_reg(REG_SHAPING_ENABLE, 16'd1);
    write_reg(UNMAPPED_INDEX_LOW, 16'hFFFF);
    write_reg(UNMAPPED_INDEX_HIGH, 16'h0001);
    send_sample(16'sd333);
    send_sample(-16'sd444);
    settle_outputs();

    // --- random phases ---
    // each phase picks an idling mode and a register setting; the samples
    // are mostly a wandering audio-like signal so the error feedback keeps
    // working across beats, with full-scale hits, near-silence and noise
    trend = 0;
    for (phase = 0; phase < 20; phase++) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 27; stall_pct = 27; end
      endcase
      case (phase % 5)
        0: write_reg(REG_PWM_PERIOD, 16'd1);
        1: write_reg(REG_PWM_PERIOD, 16'hFFFF);
        2: write_reg(REG_PWM_PERIOD, 16'($urandom_range(1, 1023)));
        3: write_reg(REG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
        default: write_reg(REG_PWM_PERIOD, 16'd0);
      endcase
      // shaping mostly on, and both settings seen for every period choice
      if (phase < 10) write_reg(REG_SHAPING_ENABLE, 16'(phase % 2 == 0));
      else write_reg(REG_SHAPING_ENABLE, 16'($urandom_range(99) < 70));

      for (k = 0; k < 61; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          s = pick[0] ? 16'sh7FFF : 16'sh8000;
        end else if (pick < 25) begin
          s = 16'($urandom_range(0, 255)) - 16'sd128;
        end else if (pick < 65) begin
          trend = trend + $urandom_range(0, 4000) - 2000;
          if (trend > 32767) trend = 32767;
          if (trend < -32768) trend = -32768;
          s = 16'(trend);
        end else begin
          s = 16'($urandom);
        end
        send_sample(s);
      end
      // sender holds off until the whole phase has come back
      settle_outputs();
    end

    gap_pct   = 0;
    stall_pct = 0;
    settle_outputs();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### pwm_audio_noise_shaped_duty_unit.f
sv/pwmns_pkg.sv
sv/pwmns_duty.sv
sv/pwmns_level.sv
sv/pwm_audio_noise_shaped_duty_unit.sv
tb/sv/pwm_duty_checker.sv
tb/sv/pwm_audio_noise_shaped_duty_unit_tb.sv
